@@ rtl/sgps_pkg.sv @@
// Package for the point smoother: payload types, phase codes and register indexes.
package sgps_pkg;

  localparam int COORD_BITS = 24;
  localparam int COEFF_BITS = 18;
  localparam int POS_BITS   = 16;
  localparam int NCOEFF     = 6;
  localparam int CFG_AW     = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_AW-1:0] REG_WRAP   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEFF0 = 3'd2;

  // Reset weights, Q2.16
  localparam logic signed [COEFF_BITS-1:0] COEFF_RST [NCOEFF] = '{
    18'sd31832, 18'sd22469, -18'sd5617, 18'sd0, 18'sd0, 18'sd0
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         seq_last;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic        [POS_BITS-1:0]   position;
    logic                         run_last;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  // Issue phases of one transaction's results
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SHORT,
    PH_HEAD,
    PH_MID,
    PH_TAIL,
    PH_WRAP
  } ph_t;

endpackage

@@ rtl/savitzky_golay_point_smoother.sv @@
// Savitzky-Golay point smoother: window shift line, result issue sequencer, MAC pipeline.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | in_data  (point_x, point_y, seq_last)
//  out     | out_valid / out_ready| out_data (out_x, out_y, position, run_last)
//  cfg     | cfg_we               | cfg_addr, cfg_wdata
//
// One point per cycle while the output does not stall and each point gives one result;
// results pass the product, pair-sum and final-sum (rounding, saturation) registers.
// A point that causes more than one result holds in_ready low while the issue
// sequencer walks a short sequence, the raw head, raw tail or the wrap flush (2*radius).
// Reset (synchronous, rst_n low) clears window, counters, valids; config gets defaults.
// An output stall freezes the pipeline and sequencer; an idle sequencer still takes a point.
module savitzky_golay_point_smoother
  import sgps_pkg::*;
#(
  parameter int MAX_RADIUS = 5,
  parameter int MAX_LENGTH = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [COEFF_BITS-1:0] cfg_wdata
);

  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int HEAD  = 2 * MAX_RADIUS;
  localparam int AW    = $clog2(WIN);
  localparam int HW    = $clog2(HEAD);
  localparam int SW    = $clog2(HEAD + 1);
  localparam int NP    = (WIN + 1) / 2;
  localparam int PW    = COORD_BITS + COEFF_BITS;
  localparam int ACC_W = PW + 4;
  localparam int QW    = ACC_W - 16;
  localparam logic [2:0] RMAX = 3'(MAX_RADIUS);
  localparam logic [POS_BITS-1:0] NLAST = POS_BITS'(MAX_LENGTH - 1);

  // Configuration registers
  logic [2:0]                   radius_r;
  logic                         wrap_mode_r;
  logic signed [COEFF_BITS-1:0] coef_r [NCOEFF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 3'd2;
      wrap_mode_r <= 1'b0;
      for (int i = 0; i < NCOEFF; i++) coef_r[i] <= COEFF_RST[i];
    end else if (cfg_we) begin
      if (cfg_addr == REG_RADIUS) radius_r <= cfg_wdata[2:0];
      else if (cfg_addr == REG_WRAP) wrap_mode_r <= cfg_wdata[0];
      else coef_r[cfg_addr - REG_COEFF0] <= cfg_wdata;
    end
  end

  // Sequence state and issue sequencer registers
  point_t              recent_r [WIN];
  point_t              head_r   [HEAD];
  logic [POS_BITS-1:0] cnt_r, cnt_nxt;
  logic [2:0]          rad_r;
  logic                wrap_r;
  ph_t                 ph_r, ph_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] nwst_r;
  logic                tail_r;
  logic [SW-1:0]       step_r, step_nxt;

  logic                stall, in_acc, go;
  logic                job_v, job_raw, job_final;
  logic [POS_BITS-1:0] job_pos;
  point_t              raw_pt;
  logic                shift_head;
  logic [HW-1:0]       head_idx;

  logic [2:0]          r_eff;
  logic                last_eff;
  logic [POS_BITS-1:0] two_r_in, two_r, mid_pos;
  logic [AW-1:0]       age;

  assign stall = out_valid && !out_ready;
  assign r_eff = (cnt_r == '0) ? ((radius_r > RMAX) ? RMAX : radius_r) : rad_r;
  assign last_eff = in_data.seq_last || (cnt_r >= NLAST);
  assign two_r_in = POS_BITS'({r_eff, 1'b0});
  assign two_r    = POS_BITS'({rad_r, 1'b0});
  assign mid_pos  = nwst_r - POS_BITS'(rad_r);
  assign age      = AW'(nwst_r - pos_r);
  assign raw_pt   = recent_r[age];

  // Job for this cycle
  always_comb begin
    job_v = 1'b1;
    job_raw = 1'b0;
    job_final = 1'b0;
    job_pos = pos_r;
    case (ph_r)
      PH_SHORT: begin
        job_raw = 1'b1;
        job_final = (pos_r == nwst_r);
      end
      PH_HEAD: begin
        job_raw = 1'b1;
      end
      PH_MID: begin
        job_pos = mid_pos;
        job_final = !tail_r || (rad_r == 3'd0);
      end
      PH_TAIL: begin
        job_raw = 1'b1;
        job_final = (pos_r == nwst_r);
      end
      PH_WRAP: begin
        job_final = (POS_BITS'(step_r) == two_r);
      end
      default: begin
        job_v = 1'b0;
      end
    endcase
  end

  assign go       = job_v && !stall;
  assign in_ready = (ph_r == PH_IDLE) || (go && job_final);
  assign in_acc   = in_valid && in_ready;

  function automatic logic wrap_eff();
    return (cnt_r == '0) ? wrap_mode_r : wrap_r;
  endfunction

  // Next phase and counters
  always_comb begin
    ph_nxt = ph_r;
    pos_nxt = pos_r;
    step_nxt = step_r;
    shift_head = 1'b0;
    head_idx = '0;
    if (go) begin
      case (ph_r)
        PH_SHORT, PH_TAIL: begin
          if (job_final) ph_nxt = PH_IDLE;
          else pos_nxt = pos_r + 1'b1;
        end
        PH_HEAD: begin
          if (pos_r == POS_BITS'(rad_r - 3'd1)) ph_nxt = PH_MID;
          else pos_nxt = pos_r + 1'b1;
        end
        PH_MID: begin
          pos_nxt = mid_pos + 1'b1;
          if (job_final) ph_nxt = PH_IDLE;
          else if (wrap_r) begin
            ph_nxt = PH_WRAP;
            step_nxt = SW'(1);
            shift_head = 1'b1;
          end else ph_nxt = PH_TAIL;
        end
        PH_WRAP: begin
          if (job_final) ph_nxt = PH_IDLE;
          else begin
            shift_head = 1'b1;
            head_idx = step_r[HW-1:0];
            step_nxt = step_r + 1'b1;
            pos_nxt = (pos_r == nwst_r) ? '0 : pos_r + 1'b1;
          end
        end
        default: ph_nxt = PH_IDLE;
      endcase
    end
    // A new point loads its plan
    if (in_acc) begin
      pos_nxt = '0;
      if (cnt_r < two_r_in) ph_nxt = last_eff ? PH_SHORT : PH_IDLE;
      else if (cnt_r == two_r_in && !wrap_eff() && r_eff != 3'd0) ph_nxt = PH_HEAD;
      else ph_nxt = PH_MID;
    end
  end

  assign cnt_nxt = last_eff ? '0 : cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      cnt_r  <= '0;
      rad_r  <= '0;
      wrap_r <= 1'b0;
      pos_r  <= '0;
      step_r <= '0;
      nwst_r <= '0;
      tail_r <= 1'b0;
      for (int i = 0; i < WIN; i++) recent_r[i] <= '0;
    end else begin
      ph_r   <= ph_nxt;
      pos_r  <= pos_nxt;
      step_r <= step_nxt;
      if (in_acc) begin
        cnt_r  <= cnt_nxt;
        nwst_r <= cnt_r;
        tail_r <= last_eff;
        if (cnt_r == '0) begin
          rad_r  <= r_eff;
          wrap_r <= wrap_mode_r;
        end
      end
      // Window shift: new point, or a head point during the wrap flush
      if (in_acc || shift_head) begin
        for (int i = WIN - 1; i > 0; i--) recent_r[i] <= recent_r[i-1];
        if (in_acc) recent_r[0] <= '{x: in_data.point_x, y: in_data.point_y};
        else recent_r[0] <= head_r[head_idx];
      end
    end
  end

  // Head store, no reset
  always_ff @(posedge clk) begin
    if (in_acc && cnt_r < POS_BITS'(HEAD)) head_r[cnt_r[HW-1:0]] <= '{
      x: in_data.point_x, y: in_data.point_y};
  end

  // Stage 1: tap products
  logic signed [PW-1:0] p1x_r [WIN];
  logic signed [PW-1:0] p1y_r [WIN];
  logic                 s1_v_r, s1_raw_r, s1_fin_r;
  logic [POS_BITS-1:0]  s1_pos_r;
  point_t               s1_pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (!stall) s1_v_r <= job_v;
  end

  always_ff @(posedge clk) begin
    logic [AW-1:0] d;
    logic signed [COEFF_BITS-1:0] w;
    if (!stall) begin
      s1_raw_r <= job_raw;
      s1_fin_r <= job_final;
      s1_pos_r <= job_pos;
      s1_pt_r  <= raw_pt;
      for (int a = 0; a < WIN; a++) begin
        d = (AW'(a) >= AW'(rad_r)) ? AW'(a) - AW'(rad_r) : AW'(rad_r) - AW'(a);
        w = (AW'(a) <= AW'({rad_r, 1'b0})) ? coef_r[3'(d)] : '0;
        p1x_r[a] <= recent_r[a].x * w;
        p1y_r[a] <= recent_r[a].y * w;
      end
    end
  end

  // Stage 2: pair sums
  logic signed [ACC_W-1:0] s2x_r [NP];
  logic signed [ACC_W-1:0] s2y_r [NP];
  logic                    s2_v_r, s2_raw_r, s2_fin_r;
  logic [POS_BITS-1:0]     s2_pos_r;
  point_t                  s2_pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (!stall) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_raw_r <= s1_raw_r;
      s2_fin_r <= s1_fin_r;
      s2_pos_r <= s1_pos_r;
      s2_pt_r  <= s1_pt_r;
      for (int i = 0; i < NP - 1; i++) begin
        s2x_r[i] <= ACC_W'(p1x_r[2*i]) + ACC_W'(p1x_r[2*i+1]);
        s2y_r[i] <= ACC_W'(p1y_r[2*i]) + ACC_W'(p1y_r[2*i+1]);
      end
      // odd tap count: the last tap has no partner
      s2x_r[NP-1] <= ACC_W'(p1x_r[WIN-1]);
      s2y_r[NP-1] <= ACC_W'(p1y_r[WIN-1]);
    end
  end

  // Stage 3: final sum, round half up, saturate
  function automatic logic signed [COORD_BITS-1:0] rnd_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [QW-1:0]    q;
    v = acc + ACC_W'(32768);
    q = QW'(v >>> 16);
    if (&q[QW-1:COORD_BITS-1] || ~|q[QW-1:COORD_BITS-1]) return q[COORD_BITS-1:0];
    return q[QW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
  endfunction

  logic signed [ACC_W-1:0] sumx, sumy;
  always_comb begin
    sumx = '0;
    sumy = '0;
    for (int i = 0; i < NP; i++) begin
      sumx = sumx + s2x_r[i];
      sumy = sumy + s2y_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (!stall) out_valid <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      out_data.out_x    <= s2_raw_r ? s2_pt_r.x : rnd_sat(sumx);
      out_data.out_y    <= s2_raw_r ? s2_pt_r.y : rnd_sat(sumy);
      out_data.position <= s2_pos_r;
      out_data.run_last <= s2_fin_r;
    end
  end

endmodule
